FILE: rtl/lsc_pkg.sv
// Shared types and constants for the LRU sector tag cache.
// Used by lsc_line_unit and lru_sector_tag_cache; depends on nothing.
package lsc_pkg;

  // Width of the capacity register and of one key half (track or sector).
  localparam int unsigned CapW = 7;
  localparam int unsigned KeyW = 16;

  // Capacity after reset, and the default number of lines.
  localparam logic [CapW-1:0] CapResetVal = 7'd64;
  localparam int unsigned     LinesDefault = 64;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StFinal
  } lsc_state_e;

  // Status flags from the shared line unit.
  typedef struct packed {
    logic match;  // stored key equals the request key
    logic older;  // stored age is above the oldest age seen so far
  } lsc_unit_t;

endpackage

FILE: rtl/lru_sector_tag_cache.sv
// Top level of the LRU sector tag cache: sequencer, counters and result registers.
// Depends on lsc_pkg, lsc_tag_ram and lsc_line_unit.
//
// Usage: a request (req_type_i, track_i, sector_i) is taken at a rising edge with
// start high and busy low. A get looks the key up; a put inserts or refreshes it.
// The answer appears on hit_o, line_valid_o, line_index_o and evicted_o for
// exactly one cycle, marked by done_o; the receiver cannot stall it, and the
// next request may be started while that answer is shown.
// The capacity register is written through cfg_valid_i/cfg_data_i, always ready;
// write it only while the block is idle.
// Operation: lines fill from index 0 upward and are never freed, so the used count
// marks the valid lines. Each request scans all used lines through the table's
// single read port, then, unless it is a plain miss, makes a second pass that
// rewrites every used line's age through the write port. A get miss, or a new key
// at capacity zero, is answered after the scan pass alone.
// Reset empties the cache and sets the capacity to 64.
module lru_sector_tag_cache #(
  parameter int unsigned LINES = lsc_pkg::LinesDefault,
  localparam int unsigned IdxW = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     req_type_i,
  input  logic [lsc_pkg::KeyW-1:0] track_i,
  input  logic [lsc_pkg::KeyW-1:0] sector_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [lsc_pkg::CapW-1:0] cfg_data_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic                     line_valid_o,
  output logic [IdxW-1:0]          line_index_o,
  output logic                     evicted_o
);

  localparam int unsigned UsedW = $clog2(LINES + 1);
  localparam int unsigned CmpW  = (UsedW > lsc_pkg::CapW) ? UsedW : lsc_pkg::CapW;
  localparam int unsigned DataW = 2 * lsc_pkg::KeyW + IdxW;

  lsc_pkg::lsc_state_e state_q, state_d;

  logic [lsc_pkg::CapW-1:0] cap_q;
  logic [UsedW-1:0]         used_q, used_d;
  logic [UsedW-1:0]         cnt_q, cnt_d;
  logic                     rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]          rd_idx_q, rd_idx_d;
  logic                     put_q, put_d;
  logic [lsc_pkg::KeyW-1:0] trk_q, trk_d;
  logic [lsc_pkg::KeyW-1:0] sct_q, sct_d;
  logic                     found_q, found_d;
  logic [IdxW-1:0]          found_idx_q, found_idx_d;
  logic [IdxW-1:0]          found_age_q, found_age_d;
  logic                     old_any_q, old_any_d;
  logic [IdxW-1:0]          old_idx_q, old_idx_d;
  logic [IdxW-1:0]          old_age_q, old_age_d;
  logic [IdxW-1:0]          tgt_q, tgt_d;
  logic                     limit_all_q, limit_all_d;
  logic                     wr_tag_q, wr_tag_d;
  logic                     fill_q, fill_d;
  logic                     done_q, done_d;
  logic                     hit_q, hit_d;
  logic                     lv_q, lv_d;
  logic [IdxW-1:0]          idx_q, idx_d;
  logic                     ev_q, ev_d;

  logic                     rd_en;
  logic                     pass_done;
  logic [CmpW-1:0]          cap_eff;
  logic                     ram_we;
  logic [IdxW-1:0]          ram_waddr;
  logic [DataW-1:0]         ram_wdata;
  logic [DataW-1:0]         ram_rdata;
  logic [lsc_pkg::KeyW-1:0] rd_track;
  logic [lsc_pkg::KeyW-1:0] rd_sector;
  logic [IdxW-1:0]          rd_age;
  lsc_pkg::lsc_unit_t       unit_status;
  logic [IdxW-1:0]          unit_age_next;

  // Line table.
  lsc_tag_ram #(
    .Depth (LINES),
    .AddrW (IdxW),
    .DataW (DataW)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rd_track  = ram_rdata[DataW-1 -: lsc_pkg::KeyW];
  assign rd_sector = ram_rdata[IdxW +: lsc_pkg::KeyW];
  assign rd_age    = ram_rdata[IdxW-1:0];

  // Shared compare and age unit, used by both passes.
  lsc_line_unit #(
    .AgeW (IdxW)
  ) u_line_unit (
    .line_track_i  (rd_track),
    .line_sector_i (rd_sector),
    .line_age_i    (rd_age),
    .req_track_i   (trk_q),
    .req_sector_i  (sct_q),
    .best_age_i    (old_age_q),
    .limit_i       (found_age_q),
    .limit_all_i   (limit_all_q),
    .status_o      (unit_status),
    .age_next_o    (unit_age_next)
  );

  // Effective capacity, saturated to the number of lines.
  assign cap_eff = (CmpW'(cap_q) > CmpW'(LINES)) ? CmpW'(LINES) : CmpW'(cap_q);

  // A pass ends once every used line has been read and its data handled.
  assign rd_en     = ((state_q == lsc_pkg::StScan) || (state_q == lsc_pkg::StUpdate)) &&
                     (cnt_q < used_q);
  assign pass_done = (cnt_q == used_q) && !rd_pend_q;

  // Configuration register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lsc_pkg::CapResetVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Sequencer: next state, counters, table writes and results.
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    rd_pend_d   = rd_en;
    rd_idx_d    = cnt_q[IdxW-1:0];
    put_d       = put_q;
    trk_d       = trk_q;
    sct_d       = sct_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_age_d = found_age_q;
    old_any_d   = old_any_q;
    old_idx_d   = old_idx_q;
    old_age_d   = old_age_q;
    tgt_d       = tgt_q;
    limit_all_d = limit_all_q;
    wr_tag_d    = wr_tag_q;
    fill_d      = fill_q;
    done_d      = 1'b0;
    hit_d       = hit_q;
    lv_d        = lv_q;
    idx_d       = idx_q;
    ev_d        = ev_q;
    ram_we      = 1'b0;
    ram_waddr   = rd_idx_q;
    ram_wdata   = ram_rdata;

    if (rd_en) begin
      cnt_d = cnt_q + UsedW'(1);
    end

    case (state_q)
      lsc_pkg::StIdle: begin
        if (start) begin
          put_d     = req_type_i;
          trk_d     = track_i;
          sct_d     = sector_i;
          cnt_d     = '0;
          found_d   = 1'b0;
          old_any_d = 1'b0;
          state_d   = lsc_pkg::StScan;
        end
      end

      lsc_pkg::StScan: begin
        // Record the first matching line and the oldest line.
        if (rd_pend_q) begin
          if (unit_status.match && !found_q) begin
            found_d     = 1'b1;
            found_idx_d = rd_idx_q;
            found_age_d = rd_age;
          end
          if (!old_any_q || unit_status.older) begin
            old_any_d = 1'b1;
            old_idx_d = rd_idx_q;
            old_age_d = rd_age;
          end
        end
        if (pass_done) begin
          cnt_d       = '0;
          hit_d       = 1'b0;
          lv_d        = 1'b0;
          idx_d       = '0;
          ev_d        = 1'b0;
          wr_tag_d    = 1'b0;
          fill_d      = 1'b0;
          limit_all_d = 1'b1;
          if (found_q) begin
            // Hit: only lines younger than the hit line age.
            tgt_d       = found_idx_q;
            limit_all_d = 1'b0;
            hit_d       = 1'b1;
            lv_d        = 1'b1;
            idx_d       = found_idx_q;
            state_d     = lsc_pkg::StUpdate;
          end else if (put_q && (cap_eff != '0)) begin
            wr_tag_d = 1'b1;
            lv_d     = 1'b1;
            if (CmpW'(used_q) < cap_eff) begin
              // Take the lowest free line, which is the next unused one.
              tgt_d  = used_q[IdxW-1:0];
              idx_d  = used_q[IdxW-1:0];
              fill_d = 1'b1;
            end else begin
              // Reuse the least recent line.
              tgt_d = old_idx_q;
              idx_d = old_idx_q;
              ev_d  = 1'b1;
            end
            state_d = lsc_pkg::StUpdate;
          end else begin
            // Miss with nothing stored: answer at once.
            done_d  = 1'b1;
            state_d = lsc_pkg::StIdle;
          end
        end
      end

      lsc_pkg::StUpdate: begin
        // Rewrite each used line's age; the target line becomes most recent.
        if (rd_pend_q) begin
          ram_we = 1'b1;
          if (rd_idx_q == tgt_q) begin
            ram_wdata = {rd_track, rd_sector, {IdxW{1'b0}}};
          end else begin
            ram_wdata = {rd_track, rd_sector, unit_age_next};
          end
        end
        if (pass_done) begin
          state_d = lsc_pkg::StFinal;
        end
      end

      lsc_pkg::StFinal: begin
        // Store the new key at the target line for an insertion, and report.
        ram_we    = wr_tag_q;
        ram_waddr = tgt_q;
        ram_wdata = {trk_q, sct_q, {IdxW{1'b0}}};
        if (fill_q) begin
          used_d = used_q + UsedW'(1);
        end
        done_d  = 1'b1;
        state_d = lsc_pkg::StIdle;
      end

      default: begin
        state_d = lsc_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lsc_pkg::StIdle;
      used_q    <= '0;
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
      done_q    <= done_d;
    end
  end

  // Request, search and result registers.
  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    put_q       <= put_d;
    trk_q       <= trk_d;
    sct_q       <= sct_d;
    found_q     <= found_d;
    found_idx_q <= found_idx_d;
    found_age_q <= found_age_d;
    old_any_q   <= old_any_d;
    old_idx_q   <= old_idx_d;
    old_age_q   <= old_age_d;
    tgt_q       <= tgt_d;
    limit_all_q <= limit_all_d;
    wr_tag_q    <= wr_tag_d;
    fill_q      <= fill_d;
    hit_q       <= hit_d;
    lv_q        <= lv_d;
    idx_q       <= idx_d;
    ev_q        <= ev_d;
  end

  assign busy         = (state_q != lsc_pkg::StIdle);
  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign line_valid_o = lv_q;
  assign line_index_o = idx_q;
  assign evicted_o    = ev_q;

  // The result is shown only after the sequencer has returned to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy)
    else $error("result shown while busy");

  // A result without a valid line reports index zero and no hit or eviction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !line_valid_o) |-> (line_index_o == '0) && !hit_o && !evicted_o)
    else $error("invalid result carries line data");

  // A hit always names a line and never evicts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && hit_o) |-> line_valid_o && !evicted_o)
    else $error("hit result inconsistent");

  // The used count never exceeds the number of lines.
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= UsedW'(LINES))
    else $error("used count beyond line count");

  // The used count grows only together with a fresh insertion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_q != $past(used_q)) |-> $past(state_q == lsc_pkg::StFinal) && $past(fill_q))
    else $error("used count changed outside an insertion");

endmodule

FILE: rtl/lsc_tag_ram.sv
// Line table memory: one write port and one read port with registered data.
// Holds track, sector and recency age for each line; no dependencies.
module lsc_tag_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 38
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port with the output registered.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: rtl/lsc_line_unit.sv
// Shared per-line unit: key compare, age compare and age increment.
// Depends on lsc_pkg for the key width and the status struct.
module lsc_line_unit #(
  parameter int unsigned AgeW = 6
) (
  input  logic [lsc_pkg::KeyW-1:0] line_track_i,
  input  logic [lsc_pkg::KeyW-1:0] line_sector_i,
  input  logic [AgeW-1:0]          line_age_i,
  input  logic [lsc_pkg::KeyW-1:0] req_track_i,
  input  logic [lsc_pkg::KeyW-1:0] req_sector_i,
  input  logic [AgeW-1:0]          best_age_i,
  input  logic [AgeW-1:0]          limit_i,
  input  logic                     limit_all_i,
  output lsc_pkg::lsc_unit_t       status_o,
  output logic [AgeW-1:0]          age_next_o
);

  // Key match and the oldest-line compare used during the scan pass.
  always_comb begin
    status_o.match = (line_track_i == req_track_i) && (line_sector_i == req_sector_i);
    status_o.older = (line_age_i > best_age_i);
  end

  // A line younger than the limit, or every line when limit_all_i is set, ages by one during the update pass.
  assign age_next_o = (limit_all_i || (line_age_i < limit_i)) ? line_age_i + AgeW'(1)
                                                               : line_age_i;

endmodule
